// File: hdl/sdc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the restoring division step for the signed
// divide-by-constant block. No dependencies.
package sdc_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned SHIFT_W = 5;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned EXP_W   = 6;

    localparam logic [WORD_W-1:0] SIGN_BIT      = 32'h8000_0000;
    localparam logic [WORD_W-1:0] DIVISOR_RESET = 32'd1;
    localparam logic [CNT_W-1:0]  CNT_LAST      = 5'd31;
    localparam logic [EXP_W-1:0]  EXP_FIRST     = 6'd31;
    localparam logic [EXP_W-1:0]  EXP_LAST      = 6'd63;
    localparam logic [EXP_W-1:0]  EXP_BASE      = 6'd32;

    typedef struct packed {
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] rem;
    } t_div_step;

    // One step of restoring division: shift in one dividend bit, subtract if it fits.
    function automatic t_div_step div_step(input logic [WORD_W-1:0] quo,
                                           input logic [WORD_W-1:0] rem,
                                           input logic [WORD_W-1:0] den,
                                           input logic              bit_in);
        t_div_step         res;
        logic [WORD_W-1:0] part;
        part = {rem[WORD_W-2:0], bit_in};
        if (part >= den) begin
            res.quo = {quo[WORD_W-2:0], 1'b1};
            res.rem = part - den;
        end else begin
            res.quo = {quo[WORD_W-2:0], 1'b0};
            res.rem = part;
        end
        return res;
    endfunction

endpackage

// File: hdl/signed_divide_by_constant_top.sv
`timescale 1ns / 1ps
// Signed 32-bit divide by a configured constant: magic-number derivation
// sequencer and a three-stage multiply datapath. Depends on sdc_pkg.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------
//  input    | start / busy         | i_dividend
//  result   | o_valid (strobe)     | o_quotient, o_divide_by_zero
//  config   | i_divisor_we         | i_divisor
//
// One dividend word is taken per cycle while busy is low; its result word
// leaves through the input register, the product register and the result
// register. A divisor write starts the derivation sequencer, which holds busy
// high through ST_CLASS alone on zero or power-of-two magnitudes and through
// ST_CLASS, ST_MOD, ST_DIV and ST_LOOP otherwise (one division step a cycle).
// Reset restores divisor 1. Results cannot be stalled by the receiver.
module signed_divide_by_constant_top
    import sdc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [WORD_W-1:0] i_dividend,
    input  logic                     i_divisor_we,
    input  logic signed [WORD_W-1:0] i_divisor,
    output logic                     o_valid,
    output logic signed [WORD_W-1:0] o_quotient,
    output logic                     o_divide_by_zero
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_MOD,
        ST_DIV,
        ST_LOOP
    } t_state;

    // ---------------- derivation sequencer ----------------
    t_state             r_state,   n_state;
    logic [WORD_W-1:0]  r_divisor, n_divisor;
    logic [WORD_W-1:0]  r_magic,   n_magic;
    logic [SHIFT_W-1:0] r_shift,   n_shift;
    logic               r_pow2,    n_pow2;
    logic [WORD_W-1:0]  r_ad,      n_ad;
    logic               r_neg,     n_neg;
    logic [WORD_W-1:0]  r_anc,     n_anc;
    logic [WORD_W-1:0]  r_q1,      n_q1;
    logic [WORD_W-1:0]  r_r1,      n_r1;
    logic [WORD_W-1:0]  r_q2,      n_q2;
    logic [WORD_W-1:0]  r_r2,      n_r2;
    logic [CNT_W-1:0]   r_cnt,     n_cnt;
    logic [EXP_W-1:0]   r_p,       n_p;

    logic [WORD_W-1:0]  w_ad;
    logic [WORD_W-1:0]  w_ad_m1;
    logic [WORD_W-1:0]  w_t;
    logic [SHIFT_W-1:0] w_log2;
    logic               w_bit1;
    logic               w_bit2;
    t_div_step          w_st1;
    t_div_step          w_st2;
    logic [EXP_W-1:0]   w_p_nx;
    logic [EXP_W-1:0]   w_post;
    logic [WORD_W-1:0]  w_delta;
    logic               w_more;
    logic [WORD_W-1:0]  w_m;

    assign w_ad    = r_divisor[WORD_W-1] ? (32'd0 - r_divisor) : r_divisor;
    assign w_ad_m1 = w_ad - 32'd1;
    assign w_t     = SIGN_BIT + {31'd0, r_divisor[WORD_W-1]};

    // The magnitude is one-hot here, so its exponent is a plain OR encode.
    always_comb begin
        w_log2 = '0;
        for (int i = 0; i < WORD_W; i++) begin
            w_log2 = w_log2 | (w_ad[i] ? SHIFT_W'(i) : '0);
        end
    end

    always_comb begin
        case (r_state)
            ST_MOD: begin
                w_bit1 = 1'b0;
                w_bit2 = w_t[~r_cnt];
            end
            ST_DIV: begin
                w_bit1 = (r_cnt == '0);
                w_bit2 = (r_cnt == '0);
            end
            default: begin
                w_bit1 = 1'b0;
                w_bit2 = 1'b0;
            end
        endcase
    end

    assign w_st1   = div_step(r_q1, r_r1, r_anc, w_bit1);
    assign w_st2   = div_step(r_q2, r_r2, r_ad, w_bit2);
    assign w_p_nx  = r_p + 6'd1;
    assign w_post  = w_p_nx - EXP_BASE;
    assign w_delta = r_ad - w_st2.rem;
    assign w_more  = (w_st1.quo < w_delta) || ((w_st1.quo == w_delta) && (w_st1.rem == '0));
    assign w_m     = w_st2.quo + 32'd1;

    always_comb begin
        n_state   = r_state;
        n_divisor = r_divisor;
        n_magic   = r_magic;
        n_shift   = r_shift;
        n_pow2    = r_pow2;
        n_ad      = r_ad;
        n_neg     = r_neg;
        n_anc     = r_anc;
        n_q1      = r_q1;
        n_r1      = r_r1;
        n_q2      = r_q2;
        n_r2      = r_r2;
        n_cnt     = r_cnt;
        n_p       = r_p;
        case (r_state)
            ST_IDLE: begin
            end
            ST_CLASS: begin
                n_ad  = w_ad;
                n_neg = r_divisor[WORD_W-1];
                if (w_ad == '0) begin
                    n_magic = '0;
                    n_shift = '0;
                    n_pow2  = 1'b0;
                    n_state = ST_IDLE;
                end else if ((w_ad & w_ad_m1) == '0) begin
                    n_magic = w_ad_m1;
                    n_shift = w_log2;
                    n_pow2  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_q2    = '0;
                    n_r2    = '0;
                    n_cnt   = '0;
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                // Remainder of t by |d|, which gives the absolute value of nc.
                n_q2  = w_st2.quo;
                n_r2  = w_st2.rem;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == CNT_LAST) begin
                    n_anc   = w_t - 32'd1 - w_st2.rem;
                    n_q1    = '0;
                    n_r1    = '0;
                    n_q2    = '0;
                    n_r2    = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_q1  = w_st1.quo;
                n_r1  = w_st1.rem;
                n_q2  = w_st2.quo;
                n_r2  = w_st2.rem;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == CNT_LAST) begin
                    n_p     = EXP_FIRST;
                    n_state = ST_LOOP;
                end
            end
            ST_LOOP: begin
                n_q1 = w_st1.quo;
                n_r1 = w_st1.rem;
                n_q2 = w_st2.quo;
                n_r2 = w_st2.rem;
                n_p  = w_p_nx;
                if ((w_p_nx == EXP_LAST) || !w_more) begin
                    n_magic = r_neg ? (32'd0 - w_m) : w_m;
                    n_shift = w_post[SHIFT_W-1:0];
                    n_pow2  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_divisor_we) begin
            n_divisor = i_divisor;
            n_state   = ST_CLASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_divisor <= DIVISOR_RESET;
            r_magic   <= '0;
            r_shift   <= '0;
            r_pow2    <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_divisor <= n_divisor;
            r_magic   <= n_magic;
            r_shift   <= n_shift;
            r_pow2    <= n_pow2;
        end
        r_ad  <= n_ad;
        r_neg <= n_neg;
        r_anc <= n_anc;
        r_q1  <= n_q1;
        r_r1  <= n_r1;
        r_q2  <= n_q2;
        r_r2  <= n_r2;
        r_cnt <= n_cnt;
        r_p   <= n_p;
    end

    assign busy = (r_state != ST_IDLE);

    // ---------------- dividend datapath ----------------
    logic              r_a_vld;
    logic [WORD_W-1:0] r_a_n;
    logic              r_b_vld;
    logic [WORD_W-1:0] r_b_n;
    logic [WORD_W-1:0] r_b_hi;
    logic              r_c_vld;
    logic [WORD_W-1:0] r_c_q;
    logic              r_c_dz;

    logic signed [2*WORD_W-1:0] w_prod;
    logic [WORD_W-1:0]          w_sum_p2;
    logic [WORD_W-1:0]          w_sh_p2;
    logic [WORD_W-1:0]          w_corr;
    logic [WORD_W-1:0]          w_sh_m;
    logic [WORD_W-1:0]          w_q;
    logic                       w_dneg;
    logic                       w_mneg;

    assign w_prod = $signed(r_a_n) * $signed(r_magic);
    assign w_dneg = r_divisor[WORD_W-1];
    assign w_mneg = r_magic[WORD_W-1];

    always_comb begin
        // Power-of-two magnitude: bias negative dividends, then shift.
        w_sum_p2 = r_b_n + (r_b_n[WORD_W-1] ? r_magic : 32'd0);
        w_sh_p2  = WORD_W'($signed(w_sum_p2) >>> r_shift);
        // Magic path: correct the high word when the magic overflowed its sign.
        if (!w_dneg && w_mneg) begin
            w_corr = r_b_hi + r_b_n;
        end else if (w_dneg && !w_mneg) begin
            w_corr = r_b_hi - r_b_n;
        end else begin
            w_corr = r_b_hi;
        end
        w_sh_m = WORD_W'($signed(w_corr) >>> r_shift);
        if (r_divisor == '0) begin
            w_q = '0;
        end else if (r_pow2) begin
            w_q = w_dneg ? (32'd0 - w_sh_p2) : w_sh_p2;
        end else begin
            w_q = w_sh_m + {31'd0, w_sh_m[WORD_W-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
        r_a_n  <= i_dividend;
        r_b_n  <= r_a_n;
        r_b_hi <= w_prod[2*WORD_W-1:WORD_W];
        r_c_q  <= w_q;
        r_c_dz <= (r_divisor == '0);
    end

    assign o_valid          = r_c_vld;
    assign o_quotient       = r_c_q;
    assign o_divide_by_zero = r_c_dz;

endmodule

// File: hdl/sdc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for signed_divide_by_constant_top, bound to the top level.
// Depends on sdc_pkg for widths.
module sdc_checker
    import sdc_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     i_divisor_we,
    input logic                     o_valid,
    input logic signed [WORD_W-1:0] o_quotient,
    input logic                     o_divide_by_zero
);

    // Every accepted word leaves through the input, product and result registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("accepted word produced no result after three cycles");

    // No result word appears without a matching accept.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("result word without an accepted dividend");

    // A zero divisor forces the quotient to zero.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_quotient == '0))
        else $error("divide by zero with nonzero quotient");

    // A divisor write starts the derivation, which blocks new dividends.
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_divisor_we |=> busy)
        else $error("busy not raised after divisor write");

endmodule

bind signed_divide_by_constant_top sdc_checker u_sdc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_divisor_we     (i_divisor_we),
    .o_valid          (o_valid),
    .o_quotient       (o_quotient),
    .o_divide_by_zero (o_divide_by_zero)
);

// File: tb/sv/signed_divide_by_constant_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for signed_divide_by_constant_top: a queue-fed driver, a
// strobe monitor and a magic-number quotient predictor. Depends on sdc_pkg and the RTL.
module signed_divide_by_constant_top_tb;
    import sdc_pkg::*;

    localparam int RESULT_LATENCY = 3;
    localparam int IDLE_LIMIT     = 2000;
    localparam int SEGMENTS       = 24;
    localparam int SEGMENT_WORDS  = 84;
    localparam int SEGMENTS_PHASE = 8;
    localparam int SENDER_IDLE_LO = 18;
    localparam int SENDER_IDLE_HI = 61;
    localparam logic [WORD_W-1:0] INT_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] quotient;
        logic              divide_by_zero;
    } t_expected_word;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [WORD_W-1:0] i_dividend = '0;
    logic                     i_divisor_we = 1'b0;
    logic signed [WORD_W-1:0] i_divisor = '0;
    logic                     o_valid;
    logic signed [WORD_W-1:0] o_quotient;
    logic                     o_divide_by_zero;

    logic [WORD_W-1:0]  dividend_queue[$];
    t_expected_word     expected_quotients[$];
    logic               word_taken = 1'b0;
    int                 sender_idle_pct = SENDER_IDLE_LO;
    int                 error_count = 0;
    int                 idle_cycles = 0;

    // Predictor copy of the divisor and the constants derived from it.
    logic [WORD_W-1:0]  div_value = DIVISOR_RESET;
    logic [WORD_W-1:0]  div_magic = '0;
    logic [SHIFT_W-1:0] div_shift = '0;
    logic               div_pow2 = 1'b1;

    signed_divide_by_constant_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_dividend       (i_dividend),
        .i_divisor_we     (i_divisor_we),
        .i_divisor        (i_divisor),
        .o_valid          (o_valid),
        .o_quotient       (o_quotient),
        .o_divide_by_zero (o_divide_by_zero)
    );

    always #5 i_clk = ~i_clk;

    function automatic void derive_magic(input logic [WORD_W-1:0] d);
        logic              neg;
        logic [WORD_W-1:0] ad, t, anc, q1, r1, q2, r2, delta, m;
        int unsigned       p;
        neg = d[WORD_W-1];
        ad  = neg ? 32'd0 - d : d;
        div_value = d;
        if (ad == '0) begin
            div_magic = '0;
            div_shift = '0;
            div_pow2  = 1'b0;
        end else if ((ad & (ad - 32'd1)) == '0) begin
            // Bias-shift path: the magic register holds the bias |d|-1.
            p = 0;
            while (p < 31 && ad[p] == 1'b0) p++;
            div_magic = ad - 32'd1;
            div_shift = p[SHIFT_W-1:0];
            div_pow2  = 1'b1;
        end else begin
            t   = SIGN_BIT + (d >> 31);
            anc = t - 32'd1 - t % ad;
            q1  = SIGN_BIT / anc;
            r1  = SIGN_BIT - q1 * anc;
            q2  = SIGN_BIT / ad;
            r2  = SIGN_BIT - q2 * ad;
            p   = 31;
            do begin
                p++;
                q1 = q1 << 1;
                r1 = r1 << 1;
                if (r1 >= anc) begin
                    q1 = q1 + 32'd1;
                    r1 = r1 - anc;
                end
                q2 = q2 << 1;
                r2 = r2 << 1;
                if (r2 >= ad) begin
                    q2 = q2 + 32'd1;
                    r2 = r2 - ad;
                end
                delta = ad - r2;
            end while (p < 63 && (q1 < delta || (q1 == delta && r1 == '0)));
            m = q2 + 32'd1;
            if (neg) m = 32'd0 - m;
            div_magic = m;
            div_shift = SHIFT_W'(p - 32);
            div_pow2  = 1'b0;
        end
    endfunction

    function automatic t_expected_word truncated_quotient(input logic [WORD_W-1:0] n);
        t_expected_word    w;
        logic [63:0]       prod;
        logic [WORD_W-1:0] q;
        w.dividend       = n;
        w.divide_by_zero = 1'b0;
        if (div_value == '0) begin
            w.quotient       = '0;
            w.divide_by_zero = 1'b1;
            return w;
        end
        if (div_pow2) begin
            q = n;
            if (n[WORD_W-1]) q = q + div_magic;
            q = $signed(q) >>> div_shift;
            if (div_value[WORD_W-1]) q = 32'd0 - q;
        end else begin
            // Signed high word from the unsigned product, then the overflow correction.
            prod = {32'd0, n} * {32'd0, div_magic};
            q = prod[63:32];
            if (n[WORD_W-1]) q = q - div_magic;
            if (div_magic[WORD_W-1]) q = q - n;
            if (!div_value[WORD_W-1] && div_magic[WORD_W-1]) q = q + n;
            else if (div_value[WORD_W-1] && !div_magic[WORD_W-1]) q = q - n;
            q = $signed(q) >>> div_shift;
            q = q + {31'd0, q[WORD_W-1]};
        end
        w.quotient = q;
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] pick_divisor(input int seg);
        logic [WORD_W-1:0] d;
        case (seg)
            0:  d = 32'd7;
            1:  d = 32'd0 - 32'd7;
            2:  d = '0;
            3:  d = 32'hFFFF_FFFF;
            4:  d = SIGN_BIT;
            5:  d = INT_MAX;
            6:  d = 32'd3;
            7:  d = SIGN_BIT + 32'd1;
            8:  d = 32'd1;
            9:  d = 32'd641;
            10: d = 32'd2;
            11: d = 32'd0 - (32'd1 << 20);
            default: begin
                case ($urandom_range(0, 3))
                    0: d = $urandom;
                    1: d = $urandom_range(2, 1000);
                    2: d = 32'd1 << $urandom_range(0, 31);
                    default: d = $urandom >> $urandom_range(0, 31);
                endcase
                if ($urandom_range(0, 1)) d = 32'd0 - d;
            end
        endcase
        return d;
    endfunction

    function automatic logic [WORD_W-1:0] pick_dividend(input logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] n;
        logic [WORD_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: n = $urandom;
            4: n = $urandom_range(0, 200) - 100;
            5: begin
                case ($urandom_range(0, 5))
                    0: n = SIGN_BIT;
                    1: n = SIGN_BIT + 32'd1;
                    2: n = INT_MAX;
                    3: n = 32'hFFFF_FFFF;
                    4: n = '0;
                    default: n = 32'd1;
                endcase
            end
            9: n = d + $urandom_range(0, 2) - 1;
            default: begin
                // Exact multiples and their neighbors exercise the rounding boundary.
                if ($urandom_range(0, 1)) k = $urandom_range(0, 2000) - 1000;
                else k = $urandom;
                n = k * d + $urandom_range(0, 2) - 1;
            end
        endcase
        return n;
    endfunction

    task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] dividend,
                                 input logic [WORD_W-1:0] got, input logic [WORD_W-1:0] want);
        $display("MISMATCH %s: dividend %0d divisor %0d got %0d want %0d", what,
                 $signed(dividend), $signed(div_value), $signed(got), $signed(want));
        error_count++;
    endtask

    task automatic wait_drained();
        while (dividend_queue.size() != 0 || start || expected_quotients.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_divisor(input logic [WORD_W-1:0] d);
        wait_drained();
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
        @(negedge i_clk);
        i_divisor_we <= 1'b1;
        i_divisor    <= d;
        @(posedge i_clk);
        derive_magic(d);
        @(negedge i_clk);
        i_divisor_we <= 1'b0;
    endtask

    // Driver: a word stays on the bus until the block takes it.
    always @(negedge i_clk) begin
        if (!start || word_taken) begin
            if (dividend_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                start      <= 1'b1;
                i_dividend <= dividend_queue.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        word_taken <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy)
            expected_quotients.push_back(truncated_quotient(i_dividend));
    end

    // Monitor: every strobed result word is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_expected_word w;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_quotients.size() == 0) begin
                flag_mismatch("result word with none expected", 'x, o_quotient, 'x);
            end else begin
                w = expected_quotients.pop_front();
                if (o_quotient !== w.quotient)
                    flag_mismatch("quotient", w.dividend, o_quotient, w.quotient);
                if (o_divide_by_zero !== w.divide_by_zero)
                    flag_mismatch("divide_by_zero", w.dividend,
                                  {31'd0, o_divide_by_zero}, {31'd0, w.divide_by_zero});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [WORD_W-1:0] d;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words, starting from the reset divisor of one.
        dividend_queue = '{SIGN_BIT, INT_MAX, 32'd0, 32'hFFFF_FFFF, 32'd1};
        load_divisor(32'hFFFF_FFFF);
        dividend_queue = '{SIGN_BIT, INT_MAX, 32'd0 - 32'd5};
        load_divisor('0);
        dividend_queue = '{SIGN_BIT, 32'd12345};
        load_divisor(SIGN_BIT);
        dividend_queue = '{SIGN_BIT, SIGN_BIT + 32'd1, INT_MAX, 32'hFFFF_FFFF};
        load_divisor(32'd7);
        dividend_queue = '{32'd7, 32'd0 - 32'd7, 32'd6, 32'd0 - 32'd6, SIGN_BIT};
        load_divisor(INT_MAX);
        dividend_queue = '{INT_MAX, SIGN_BIT, SIGN_BIT + 32'd1};
        load_divisor(32'd0 - 32'd8);
        dividend_queue = '{32'd9, 32'd0 - 32'd9};

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            d = pick_divisor(seg);
            load_divisor(d);
            case (seg / SEGMENTS_PHASE)
                0: sender_idle_pct = SENDER_IDLE_LO;
                1: sender_idle_pct = SENDER_IDLE_HI;
                default: sender_idle_pct = 0;
            endcase
            for (int i = 0; i < SEGMENT_WORDS; i++) begin
                // Now and then the sender holds off until the pipeline has emptied.
                if (i == SEGMENT_WORDS / 2 && seg % 4 == 3) wait_drained();
                dividend_queue.push_back(pick_dividend(d));
            end
        end

        wait_drained();
        repeat (RESULT_LATENCY + 5) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
